FILE: sv/motor_link_poll_scheduler_assert.svh
// Assertion helpers shared by the scheduler modules.
// Each macro expects clk and rst_n in scope.
`ifndef MOTOR_LINK_POLL_SCHEDULER_ASSERT_SVH
`define MOTOR_LINK_POLL_SCHEDULER_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define MLPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define MLPS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MLPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mlps_pkg.sv
`default_nettype none

package mlps_pkg;

    // Outstanding request kinds
    typedef enum logic [2:0] {
        REQ_NONE   = 3'd0,
        REQ_SPEED  = 3'd1,
        REQ_STATUS = 3'd2,
        REQ_POWER  = 3'd3,
        REQ_FLUSH  = 3'd7
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCALE,
        ST_DIV_IMP,
        ST_WEIGHT,
        ST_DIV_SPD,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        CFG_ASSIST    = 3'd0,
        CFG_LIGHT     = 3'd1,
        CFG_ROAD_MODE = 3'd2,
        CFG_ROAD      = 3'd3,
        CFG_OFFROAD   = 3'd4,
        CFG_WHEEL     = 3'd5,
        CFG_IMPERIAL  = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        MUL_IMPERIAL,
        MUL_WHEEL
    } mul_sel_t;

    typedef enum logic {
        DIV_BY_IMPERIAL,
        DIV_BY_HUNDRED
    } div_sel_t;

    typedef struct packed {
        logic signed [4:0] assist_level;
        logic              light_on;
        logic              road_mode;
        logic [15:0]       road_cfg;
        logic [15:0]       offroad_cfg;
        logic [11:0]       wheel_circumference_mm;
        logic              imperial_units;
    } cfg_t;

    typedef struct packed {
        logic     eval;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     x_load;
        logic     speed_load;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic in_full;
        logic speed_go;
        logic imperial;
        logic div_done;
        logic out_free;
        logic emit_last;
    } sts_t;

    // Frame bytes
    localparam logic [7:0] REQ_HEAD       = 8'h11;
    localparam logic [7:0] CFG_HEAD       = 8'h16;
    localparam logic [7:0] OP_SPEED       = 8'h20;
    localparam logic [7:0] OP_STATUS      = 8'h08;
    localparam logic [7:0] OP_POWER       = 8'h0a;
    localparam logic [7:0] OP_PAS         = 8'h0b;
    localparam logic [7:0] OP_LIGHT       = 8'h1a;
    localparam logic [7:0] OP_CFG         = 8'h1f;
    localparam logic [7:0] PAS_SUM        = 8'h21;
    localparam logic [7:0] CFG_SUM        = 8'h35;
    localparam logic [7:0] LIGHT_ON_BYTE  = 8'hf0;
    localparam logic [7:0] LIGHT_OFF_BYTE = 8'hf1;

    // Schedule slots
    localparam logic [6:0] SLOT_SPEED_REQ  = 7'd10;
    localparam logic [6:0] SLOT_PAS        = 7'd20;
    localparam logic [6:0] SLOT_STATUS_REQ = 7'd40;
    localparam logic [6:0] SLOT_LIGHT      = 7'd50;
    localparam logic [6:0] SLOT_POWER_REQ  = 7'd70;
    localparam logic [6:0] SLOT_CFG        = 7'd80;
    localparam logic [6:0] TICK_RESTART    = 7'h7f;

    localparam logic [4:0] TIMEOUT_FIRST = 5'd30;
    localparam logic [4:0] TIMEOUT_NEXT  = 5'd15;

    // Reply lengths, also the bytes popped
    localparam logic [6:0] SPEED_REPLY_LEN  = 7'd3;
    localparam logic [6:0] STATUS_REPLY_LEN = 7'd1;
    localparam logic [6:0] POWER_REPLY_LEN  = 7'd2;

    localparam logic [14:0] IMPERIAL_NUM = 15'd1000;
    localparam logic [9:0]  IMPERIAL_DEN = 10'd621;
    localparam logic [9:0]  SCALE_DEN    = 10'd100;
    localparam logic [23:0] SPEED_MAX    = 24'hffffff;
    localparam logic [11:0] WHEEL_RESET  = 12'd2100;

    localparam int TXQ_DEPTH = 5;

    localparam logic signed [4:0] PAS_LEVEL_MIN = -5'sd1;
    localparam logic signed [4:0] PAS_LEVEL_MAX = 5'sd9;
    localparam logic [7:0] PAS_TABLE [11] = '{
        8'h06, 8'h00, 8'h01, 8'h0b, 8'h0c, 8'h0d, 8'h02, 8'h15, 8'h16, 8'h17, 8'h03
    };

    function automatic logic [7:0] pas_code(input logic signed [4:0] lvl);
        logic [3:0] idx;
        idx = 4'(lvl - PAS_LEVEL_MIN);
        if (lvl < PAS_LEVEL_MIN || lvl > PAS_LEVEL_MAX)
        begin
            return 8'h00;
        end
        return PAS_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

FILE: sv/mlps_div.sv
`default_nettype none

// Divide by one of two fixed divisors through a reciprocal multiply.
// start captures the dividend; done follows via stage_reg, done_reg.
module mlps_div
    import mlps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  div_sel_t    sel,
    input  logic [31:0] dividend,
    output logic        done,
    output logic [31:0] quotient
);

    // ceil(2^36 / 621), exact for dividends below 2^26
    localparam logic [31:0] RECIP_IMPERIAL = 32'd110659383;
    // ceil(2^37 / 100), exact for any 32-bit dividend
    localparam logic [31:0] RECIP_HUNDRED  = 32'd1374389535;

    logic        stage_reg;
    logic        done_reg;
    div_sel_t    sel_reg;
    logic [31:0] num_reg;
    logic [63:0] prod_reg;
    logic [31:0] recip;

    always_comb
    begin
        recip = (sel_reg == DIV_BY_IMPERIAL) ? RECIP_IMPERIAL : RECIP_HUNDRED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sel_reg <= sel;
            num_reg <= dividend;
        end
        if (stage_reg)
        begin
            prod_reg <= {32'b0, num_reg} * {32'b0, recip};
        end
    end

    assign done     = done_reg;
    assign quotient = (sel_reg == DIV_BY_IMPERIAL) ? {4'b0, prod_reg[63:36]}
                                                   : {5'b0, prod_reg[63:37]};

endmodule

`default_nettype wire

FILE: sv/mlps_datapath.sv
`default_nettype none
`include "motor_link_poll_scheduler_assert.svh"

// Tick state, frame builder, speed arithmetic and the input/output registers.
module mlps_datapath
    import mlps_pkg::*;
#(
    parameter int RX_DEPTH        = 64,
    parameter int SCHEDULE_PERIOD = 90
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        tx_ready,
    input  logic [6:0]  rx_count,
    input  logic [7:0]  rx_first,
    input  logic [7:0]  rx_second,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic [6:0]  rx_pop,
    output logic [23:0] speed,
    output logic [7:0]  error_code,
    output logic [7:0]  power,
    output logic        timed_out,
    output logic        last
);

    localparam logic [8:0] DEPTH_CAP  = 9'(RX_DEPTH);
    localparam logic [6:0] PERIOD_END = 7'(SCHEDULE_PERIOD);

    // input buffer
    logic        in_full_reg;
    logic        in_tx_ready_reg;
    logic [6:0]  in_count_reg;
    logic [7:0]  in_first_reg, in_second_reg;

    // link state
    req_t        pending_reg, pending_next;
    logic        awaiting_reg, awaiting_next;
    logic [6:0]  seen_reg, seen_next;
    logic [4:0]  timeout_reg, timeout_next;
    logic [6:0]  tick_reg, tick_next;
    logic [23:0] held_speed_reg;
    logic [7:0]  held_error_reg, held_error_next;
    logic [7:0]  held_power_reg, held_power_next;

    // per-tick results
    logic [6:0]  pop_reg, pop_next;
    logic        tmo_reg, tmo_next;
    logic [7:0]  txq_reg [TXQ_DEPTH];
    logic [7:0]  txq_next [TXQ_DEPTH];
    logic [2:0]  txn_reg, txn_next;
    logic [2:0]  emit_idx_reg;

    // speed arithmetic
    logic [16:0] x_reg;
    logic [14:0] wheel6, mul_b;
    logic [31:0] mul_prod;
    logic        div_done;
    logic [31:0] div_quo;

    // output register
    logic        out_valid_reg;
    logic        out_tx_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [6:0]  out_pop_reg;
    logic [23:0] out_speed_reg;
    logic [7:0]  out_error_reg, out_power_reg;
    logic        out_tmo_reg, out_last_reg;

    logic        accept;
    logic        speed_go;
    logic        run_sched;
    logic        reply_go;
    logic        emit_last;
    logic [6:0]  rx_avail;
    logic [6:0]  tick_inc;
    logic [7:0]  pas_byte;
    logic [15:0] cfg_sel;

    assign accept   = in_valid && !in_full_reg;
    assign in_stall = in_full_reg;

    always_comb
    begin
        rx_avail = ({2'b00, in_count_reg} > DEPTH_CAP) ? DEPTH_CAP[6:0] : in_count_reg;
        tick_inc = tick_reg + 7'd1;
        pas_byte = pas_code(cfg.assist_level);
        cfg_sel  = cfg.road_mode ? cfg.road_cfg : cfg.offroad_cfg;
    end

    // One tick of the link master
    always_comb
    begin
        pending_next    = pending_reg;
        awaiting_next   = awaiting_reg;
        seen_next       = seen_reg;
        timeout_next    = timeout_reg;
        tick_next       = tick_reg;
        held_error_next = held_error_reg;
        held_power_next = held_power_reg;
        pop_next        = '0;
        tmo_next        = 1'b0;
        txn_next        = '0;
        for (int i = 0; i < TXQ_DEPTH; i++)
        begin
            txq_next[i] = 8'h00;
        end
        speed_go  = 1'b0;
        run_sched = 1'b0;
        reply_go  = 1'b0;

        if (in_tx_ready_reg)
        begin
            if (pending_reg != REQ_NONE)
            begin
                if (awaiting_reg)
                begin
                    awaiting_next = 1'b0;
                    seen_next     = '0;
                    timeout_next  = TIMEOUT_FIRST;
                    reply_go      = 1'b1;
                end
                else if (rx_avail != seen_reg)
                begin
                    timeout_next = TIMEOUT_NEXT;
                    seen_next    = rx_avail;
                    reply_go     = 1'b1;
                end
                else if (timeout_reg <= 5'd1)
                begin
                    timeout_next = '0;
                    pending_next = REQ_NONE;
                    tmo_next     = 1'b1;
                end
                else
                begin
                    timeout_next = timeout_reg - 5'd1;
                end

                if (reply_go)
                begin
                    case (pending_reg)
                        REQ_SPEED:
                        begin
                            if (rx_avail >= SPEED_REPLY_LEN)
                            begin
                                speed_go     = 1'b1;
                                pop_next     = SPEED_REPLY_LEN;
                                pending_next = REQ_FLUSH;
                            end
                        end
                        REQ_STATUS:
                        begin
                            if (rx_avail >= STATUS_REPLY_LEN)
                            begin
                                held_error_next = in_first_reg;
                                pop_next        = STATUS_REPLY_LEN;
                                pending_next    = REQ_FLUSH;
                            end
                        end
                        REQ_POWER:
                        begin
                            if (rx_avail >= POWER_REPLY_LEN)
                            begin
                                held_power_next = in_first_reg;
                                pop_next        = POWER_REPLY_LEN;
                                pending_next    = REQ_FLUSH;
                            end
                        end
                        REQ_FLUSH:
                        begin
                            pop_next     = rx_avail;
                            pending_next = REQ_NONE;
                        end
                        default:
                        begin
                            run_sched = 1'b1;
                        end
                    endcase
                end
            end
            else
            begin
                run_sched = 1'b1;
            end
        end

        if (run_sched)
        begin
            tick_next = tick_inc;
            case (tick_inc)
                SLOT_SPEED_REQ:
                begin
                    txq_next[0]   = REQ_HEAD;
                    txq_next[1]   = OP_SPEED;
                    txn_next      = 3'd2;
                    pending_next  = REQ_SPEED;
                    awaiting_next = 1'b1;
                end
                SLOT_PAS:
                begin
                    txq_next[0] = CFG_HEAD;
                    txq_next[1] = OP_PAS;
                    txq_next[2] = pas_byte;
                    txq_next[3] = pas_byte + PAS_SUM;
                    txn_next    = 3'd4;
                end
                SLOT_STATUS_REQ:
                begin
                    txq_next[0]   = REQ_HEAD;
                    txq_next[1]   = OP_STATUS;
                    txn_next      = 3'd2;
                    pending_next  = REQ_STATUS;
                    awaiting_next = 1'b1;
                end
                SLOT_LIGHT:
                begin
                    txq_next[0] = CFG_HEAD;
                    txq_next[1] = OP_LIGHT;
                    txq_next[2] = cfg.light_on ? LIGHT_ON_BYTE : LIGHT_OFF_BYTE;
                    txn_next    = 3'd3;
                end
                SLOT_POWER_REQ:
                begin
                    txq_next[0]   = REQ_HEAD;
                    txq_next[1]   = OP_POWER;
                    txn_next      = 3'd2;
                    pending_next  = REQ_POWER;
                    awaiting_next = 1'b1;
                end
                SLOT_CFG:
                begin
                    txq_next[0] = CFG_HEAD;
                    txq_next[1] = OP_CFG;
                    txq_next[2] = cfg_sel[15:8];
                    txq_next[3] = cfg_sel[7:0];
                    txq_next[4] = cfg_sel[15:8] + cfg_sel[7:0] + CFG_SUM;
                    txn_next    = 3'd5;
                end
                default:
                begin
                    if (tick_inc >= PERIOD_END)
                    begin
                        tick_next = TICK_RESTART;
                    end
                end
            endcase
        end
    end

    // Shared multiplier: raw * 1000, then x * wheel * 6
    assign wheel6   = {1'b0, cfg.wheel_circumference_mm, 2'b00}
                    + {2'b00, cfg.wheel_circumference_mm, 1'b0};
    assign mul_b    = (cmd.mul_sel == MUL_IMPERIAL) ? IMPERIAL_NUM : wheel6;
    assign mul_prod = {15'b0, x_reg} * {17'b0, mul_b};

    mlps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .sel      (cmd.div_sel),
        .dividend (mul_prod),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign emit_last = (txn_reg == 3'd0) || (emit_idx_reg == txn_reg - 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            pending_reg    <= REQ_NONE;
            awaiting_reg   <= 1'b0;
            seen_reg       <= '0;
            timeout_reg    <= '0;
            tick_reg       <= TICK_RESTART;
            held_speed_reg <= '0;
            held_error_reg <= '0;
            held_power_reg <= '0;
            pop_reg        <= '0;
            tmo_reg        <= 1'b0;
            txn_reg        <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                in_full_reg <= 1'b0;
            end
            else if (accept)
            begin
                in_full_reg <= 1'b1;
            end

            if (cmd.eval)
            begin
                pending_reg    <= pending_next;
                awaiting_reg   <= awaiting_next;
                seen_reg       <= seen_next;
                timeout_reg    <= timeout_next;
                tick_reg       <= tick_next;
                held_error_reg <= held_error_next;
                held_power_reg <= held_power_next;
                pop_reg        <= pop_next;
                tmo_reg        <= tmo_next;
                txn_reg        <= txn_next;
                emit_idx_reg   <= '0;
            end
            else if (cmd.emit)
            begin
                emit_idx_reg <= emit_idx_reg + 3'd1;
            end

            if (cmd.speed_load)
            begin
                held_speed_reg <= (|div_quo[31:24]) ? SPEED_MAX : div_quo[23:0];
            end

            out_valid_reg <= cmd.emit || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_tx_ready_reg <= tx_ready;
            in_count_reg    <= rx_count;
            in_first_reg    <= rx_first;
            in_second_reg   <= rx_second;
        end

        if (cmd.eval)
        begin
            for (int i = 0; i < TXQ_DEPTH; i++)
            begin
                txq_reg[i] <= txq_next[i];
            end
        end

        if (cmd.eval && speed_go)
        begin
            x_reg <= {1'b0, in_first_reg, in_second_reg};
        end
        else if (cmd.x_load)
        begin
            x_reg <= div_quo[16:0];
        end

        if (cmd.emit)
        begin
            out_tx_valid_reg <= (txn_reg != 3'd0);
            out_byte_reg     <= (txn_reg != 3'd0) ? txq_reg[emit_idx_reg] : 8'h00;
            out_pop_reg      <= (emit_idx_reg == 3'd0) ? pop_reg : 7'd0;
            out_tmo_reg      <= (emit_idx_reg == 3'd0) ? tmo_reg : 1'b0;
            out_last_reg     <= emit_last;
            out_speed_reg    <= held_speed_reg;
            out_error_reg    <= held_error_reg;
            out_power_reg    <= held_power_reg;
        end
    end

    always_comb
    begin
        sts.in_full   = in_full_reg;
        sts.speed_go  = speed_go;
        sts.imperial  = cfg.imperial_units;
        sts.div_done  = div_done;
        sts.out_free  = !out_valid_reg || !out_stall;
        sts.emit_last = emit_last;
    end

    assign out_valid  = out_valid_reg;
    assign tx_valid   = out_tx_valid_reg;
    assign tx_byte    = out_byte_reg;
    assign rx_pop     = out_pop_reg;
    assign speed      = out_speed_reg;
    assign error_code = out_error_reg;
    assign power      = out_power_reg;
    assign timed_out  = out_tmo_reg;
    assign last       = out_last_reg;

    `MLPS_ASSERT_ALWAYS(a_await_has_req, !awaiting_reg || (pending_reg != REQ_NONE), "awaiting reply with no request")
    `MLPS_ASSERT_ALWAYS(a_timeout_range, timeout_reg <= TIMEOUT_FIRST, "timeout counter out of range")
    `MLPS_ASSERT_IMPLIES(a_tmo_no_pop, tmo_reg, pop_reg == 7'd0, "timeout tick also popped bytes")

endmodule

`default_nettype wire

FILE: sv/mlps_ctrl.sv
`default_nettype none
`include "motor_link_poll_scheduler_assert.svh"

// Sequencer: evaluate a tick, run the speed arithmetic if needed, emit results.
module mlps_ctrl
    import mlps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.eval       = 1'b0;
        cmd.mul_sel    = MUL_IMPERIAL;
        cmd.div_start  = 1'b0;
        cmd.div_sel    = DIV_BY_IMPERIAL;
        cmd.x_load     = 1'b0;
        cmd.speed_load = 1'b0;
        cmd.emit       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (sts.in_full)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.speed_go)
                begin
                    state_next = sts.imperial ? ST_SCALE : ST_WEIGHT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCALE:
            begin
                cmd.mul_sel   = MUL_IMPERIAL;
                cmd.div_sel   = DIV_BY_IMPERIAL;
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_IMP;
            end
            ST_DIV_IMP:
            begin
                if (sts.div_done)
                begin
                    cmd.x_load = 1'b1;
                    state_next = ST_WEIGHT;
                end
            end
            ST_WEIGHT:
            begin
                cmd.mul_sel   = MUL_WHEEL;
                cmd.div_sel   = DIV_BY_HUNDRED;
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_SPD;
            end
            ST_DIV_SPD:
            begin
                if (sts.div_done)
                begin
                    cmd.speed_load = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `MLPS_ASSERT_NEXT(a_eval_to_speed, (state_reg == ST_EVAL) && sts.speed_go, (state_reg == ST_SCALE) || (state_reg == ST_WEIGHT), "speed reply did not start arithmetic")
    `MLPS_ASSERT_IMPLIES(a_done_in_wait, sts.div_done, (state_reg == ST_DIV_IMP) || (state_reg == ST_DIV_SPD), "divider finished outside a wait state")
    `MLPS_ASSERT_IMPLIES(a_eval_has_item, state_reg == ST_EVAL, sts.in_full, "tick evaluated without a buffered transaction")

endmodule

`default_nettype wire

FILE: sv/motor_link_poll_scheduler.sv
// Motor-controller UART link master, one transaction per software tick.
// Input channel (in_valid / in_stall): tx_ready, rx_count and the three
// oldest receive bytes. A one-entry input buffer takes the next tick while
// the current one is still being worked on or emitted.
// Output channel (out_valid / out_stall): one transaction per byte to send,
// or a single idle transaction when nothing is sent; last marks the final
// one of a tick. rx_pop and timed_out ride on the first transaction only.
// Each tick gives n results (1..5). A complete speed reply first runs the
// speed arithmetic in the shared divider: one reciprocal multiply for the
// divide by 100, preceded with imperial units by one for 621. The first
// result is registered from the emit state, reached after the evaluate state.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready; writes to unknown indexes are dropped.
// Reset: schedule counter at all ones, no request pending, held values and
// config registers at their defaults, both channels empty.
// A stalled receiver holds the output register; the sequencer waits in its
// emit state, and at most one further tick is buffered on the input side.
`default_nettype none

module motor_link_poll_scheduler
    import mlps_pkg::*;
#(
    parameter int RX_DEPTH        = 64,
    parameter int SCHEDULE_PERIOD = 90
)
(
    input  logic        clk,
    input  logic        rst_n,
    // tick input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        tx_ready,
    input  logic [6:0]  rx_count,
    input  logic [7:0]  rx_first,
    input  logic [7:0]  rx_second,
    input  logic [7:0]  rx_third,
    // results
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic [6:0]  rx_pop,
    output logic [23:0] speed,
    output logic [7:0]  error_code,
    output logic [7:0]  power,
    output logic        timed_out,
    output logic        last,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // Config register file; rx_third is never needed by any reply.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.assist_level           <= 5'sd0;
            cfg_reg.light_on               <= 1'b0;
            cfg_reg.road_mode              <= 1'b1;
            cfg_reg.road_cfg               <= '0;
            cfg_reg.offroad_cfg            <= '0;
            cfg_reg.wheel_circumference_mm <= WHEEL_RESET;
            cfg_reg.imperial_units         <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ASSIST:    cfg_reg.assist_level           <= cfg_data[4:0];
                CFG_LIGHT:     cfg_reg.light_on               <= cfg_data[0];
                CFG_ROAD_MODE: cfg_reg.road_mode              <= cfg_data[0];
                CFG_ROAD:      cfg_reg.road_cfg               <= cfg_data;
                CFG_OFFROAD:   cfg_reg.offroad_cfg            <= cfg_data;
                CFG_WHEEL:     cfg_reg.wheel_circumference_mm <= cfg_data[11:0];
                CFG_IMPERIAL:  cfg_reg.imperial_units         <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    mlps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    mlps_datapath #(
        .RX_DEPTH        (RX_DEPTH),
        .SCHEDULE_PERIOD (SCHEDULE_PERIOD)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .sts        (sts),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .tx_ready   (tx_ready),
        .rx_count   (rx_count),
        .rx_first   (rx_first),
        .rx_second  (rx_second),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .rx_pop     (rx_pop),
        .speed      (speed),
        .error_code (error_code),
        .power      (power),
        .timed_out  (timed_out),
        .last       (last)
    );

endmodule

`default_nettype wire
